FILE: hdl/rcba_pkg.sv
// ----------------------------------------------------------------------------
// rcba_pkg
// Shared constants, codes, types and helper functions of the reference
// counted block allocator.
// ----------------------------------------------------------------------------
package rcba_pkg;

    // Table geometry.
    localparam int NUM_BLOCKS = 1024;
    localparam int REF_WIDTH  = 16;
    localparam int IDX_W      = 10;
    localparam int WORD_W     = 32;
    localparam int BIT_W      = $clog2(WORD_W);
    localparam int NUM_WORDS  = NUM_BLOCKS / WORD_W;
    localparam int WIDX_W     = $clog2(NUM_WORDS);
    localparam int USED_W     = IDX_W + 1;
    localparam int MARK_W     = 32;

    localparam logic [IDX_W:0] BLOCK_LIMIT = (IDX_W + 1)'(NUM_BLOCKS);

    // Request codes.
    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_RELEASE = 2'd1;
    localparam logic [1:0] REQ_MARK    = 2'd2;
    localparam logic [1:0] REQ_QUERY   = 2'd3;

    // Status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_ALLOC = 2'd2;

    // One entry of the block table.
    typedef struct packed {
        logic                 in_mem;
        logic [REF_WIDTH-1:0] count;
    } entry_t;

    // Position of the lowest set bit of a word; zero when no bit is set.
    function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] vec);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (vec[i]) begin
                pos = BIT_W'(i);
            end
        end
        return pos;
    endfunction

    // Position of the lowest set bit of the word summary; zero when empty.
    function automatic logic [WIDX_W-1:0] lowest_word(input logic [NUM_WORDS-1:0] vec);
        logic [WIDX_W-1:0] pos;
        pos = '0;
        for (int i = NUM_WORDS - 1; i >= 0; i--) begin
            if (vec[i]) begin
                pos = WIDX_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

FILE: hdl/rcba_ram.sv
// ----------------------------------------------------------------------------
// rcba_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module rcba_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/refcounted_block_allocator.sv
// ----------------------------------------------------------------------------
// refcounted_block_allocator
// Reference counted block allocator with in-memory flags and a two-level
// free search.
// ----------------------------------------------------------------------------
// The block keeps a table of 1024 physical blocks, each with a 16-bit
// reference count and an in-memory flag, and serves four requests: allocate
// (claim the lowest free block with a count of one), release (drop a
// reference, freeing the block when the count reaches zero), mark in memory,
// and query. Every request transfer produces exactly one result transfer.
// After reset the block runs a clearing pass, one table entry per cycle, and
// accepts no request until it is done. A request is then handled one at a
// time, in steps: release, mark and query (accept, table read, update),
// allocate (accept, bitmap read, pick, entry read, update), and allocate on
// a full table (accept, update). The steps come from the registered read of
// the table RAM and of the free bitmap RAM: allocation first picks the
// lowest 32-block group with a free block from a summary register, then
// reads that group's bitmap word to pick the block, then reads the block's
// entry. A result that is not taken holds the block in its update step.
// ----------------------------------------------------------------------------
module refcounted_block_allocator (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_req_type,
    input  logic [rcba_pkg::IDX_W-1:0]     s_block_index,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [rcba_pkg::IDX_W-1:0]     m_result_index,
    output logic [1:0]                     m_status,
    output logic                           m_block_free,
    output logic                           m_block_in_memory,
    output logic                           m_block_freed,
    output logic [rcba_pkg::USED_W-1:0]    m_used_blocks,
    output logic [rcba_pkg::MARK_W-1:0]    m_in_memory_marks
);

    import rcba_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_PICK,
        ST_EXEC
    } state_t;

    // Sequencer and request registers.
    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [1:0]             req_reg, req_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic                   full_reg, full_next;
    logic                   picked_reg, picked_next;

    // One bit per 32-block group: the group still holds a free block.
    logic [NUM_WORDS-1:0]   summary_reg, summary_next;
    logic [USED_W-1:0]      used_reg, used_next;
    logic [MARK_W-1:0]      marks_reg, marks_next;

    // Result register.
    logic                   m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]       res_idx_reg, res_idx_next;
    logic [1:0]             status_reg, status_next;
    logic                   free_reg, free_next;
    logic                   in_mem_reg, in_mem_next;
    logic                   freed_reg, freed_next;

    // Memory ports.
    entry_t                 ent_rdata, ent_wdata;
    logic [WORD_W-1:0]      bm_rdata, bm_wdata;
    logic                   ram_we;
    logic [IDX_W-1:0]       ent_waddr;
    logic [WIDX_W-1:0]      bm_waddr;

    // Update step results.
    entry_t                 x_entry;
    logic [WORD_W-1:0]      x_word;
    logic                   x_write;
    logic [IDX_W-1:0]       x_res_idx;
    logic [1:0]             x_status;
    logic                   x_free;
    logic                   x_in_mem;
    logic                   x_freed;
    logic [USED_W-1:0]      x_used;
    logic [MARK_W-1:0]      x_marks;
    logic                   exec_fire;

    logic [WIDX_W-1:0]      word_sel;
    logic [BIT_W-1:0]       bit_sel;

    assign word_sel = idx_reg[IDX_W-1 -: WIDX_W];
    assign bit_sel  = idx_reg[BIT_W-1:0];

    // The update step completes once the result register can take a new item.
    assign exec_fire = (state_reg == ST_EXEC) && (!m_valid_reg || m_ready);

    // Reference counts and in-memory flags, one entry per block.
    rcba_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (NUM_BLOCKS)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (idx_reg),
        .rdata (ent_rdata)
    );

    // Allocation bitmap, one bit per block, set while the block is in use.
    rcba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_WORDS)
    ) u_bitmap_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .raddr (word_sel),
        .rdata (bm_rdata)
    );

    // During the clearing pass both memories are written with zero; afterwards
    // they are written only when an update step changes the table.
    always_comb begin
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ent_waddr = clr_cnt_reg;
            bm_waddr  = clr_cnt_reg[IDX_W-1 -: WIDX_W];
            ent_wdata = '0;
            bm_wdata  = '0;
        end else begin
            ram_we    = exec_fire && x_write;
            ent_waddr = idx_reg;
            bm_waddr  = word_sel;
            ent_wdata = x_entry;
            bm_wdata  = x_word;
        end
    end

    // Update step: works on the entry and bitmap word read in the fetch step.
    always_comb begin
        x_entry   = ent_rdata;
        x_word    = bm_rdata;
        x_write   = 1'b0;
        x_res_idx = idx_reg;
        x_status  = STATUS_OK;
        x_free    = 1'b1;
        x_in_mem  = 1'b0;
        x_freed   = 1'b0;
        x_used    = used_reg;
        x_marks   = marks_reg;

        if (req_reg == REQ_ALLOC) begin
            if (full_reg) begin
                x_res_idx = '0;
                x_status  = STATUS_FULL;
                x_free    = 1'b0;
            end else begin
                // The claimed block keeps its in-memory flag.
                x_entry.count   = REF_WIDTH'(1);
                x_word[bit_sel] = 1'b1;
                x_write         = 1'b1;
                x_used          = used_reg + 1'b1;
                x_free          = (x_entry.count == '0);
                x_in_mem        = ent_rdata.in_mem;
            end
        end else if ({1'b0, idx_reg} >= BLOCK_LIMIT) begin
            x_status = STATUS_NOT_ALLOC;
        end else begin
            unique case (req_reg) inside
                REQ_RELEASE: begin
                    if (ent_rdata.count == '0) begin
                        x_status = STATUS_NOT_ALLOC;
                    end else begin
                        x_entry.count = ent_rdata.count - 1'b1;
                        x_write       = 1'b1;
                        if (x_entry.count == '0) begin
                            x_entry.in_mem  = 1'b0;
                            x_word[bit_sel] = 1'b0;
                            x_freed         = 1'b1;
                            if (used_reg != '0) begin
                                x_used = used_reg - 1'b1;
                            end
                        end
                    end
                end
                REQ_MARK: begin
                    x_entry.in_mem = 1'b1;
                    x_write        = 1'b1;
                    x_marks        = marks_reg + 1'b1;
                end
                REQ_ALLOC, REQ_QUERY: begin
                end
            endcase
            x_free   = (x_entry.count == '0);
            x_in_mem = x_entry.in_mem;
        end
    end

    // Sequencer.
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        req_next     = req_reg;
        idx_next     = idx_reg;
        full_next    = full_reg;
        picked_next  = picked_reg;
        summary_next = summary_reg;
        used_next    = used_reg;
        marks_next   = marks_reg;
        m_valid_next = m_valid_reg;
        res_idx_next = res_idx_reg;
        status_next  = status_reg;
        free_next    = free_reg;
        in_mem_next  = in_mem_reg;
        freed_next   = freed_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    req_next    = s_req_type;
                    picked_next = 1'b0;
                    if (s_req_type == REQ_ALLOC) begin
                        // First level of the free search: lowest group with room.
                        idx_next   = {lowest_word(summary_reg), {BIT_W{1'b0}}};
                        full_next  = ~|summary_reg;
                        state_next = (~|summary_reg) ? ST_EXEC : ST_FETCH;
                    end else begin
                        idx_next   = s_block_index;
                        full_next  = 1'b0;
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                if (req_reg == REQ_ALLOC && !picked_reg) begin
                    state_next = ST_PICK;
                end else begin
                    state_next = ST_EXEC;
                end
            end
            ST_PICK: begin
                // Second level of the free search: lowest clear bit of the group.
                idx_next    = {word_sel, lowest_set(~bm_rdata)};
                picked_next = 1'b1;
                state_next  = ST_FETCH;
            end
            ST_EXEC: begin
                if (exec_fire) begin
                    if (x_write) begin
                        summary_next[word_sel] = ~&x_word;
                    end
                    used_next    = x_used;
                    marks_next   = x_marks;
                    m_valid_next = 1'b1;
                    res_idx_next = x_res_idx;
                    status_next  = x_status;
                    free_next    = x_free;
                    in_mem_next  = x_in_mem;
                    freed_next   = x_freed;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            full_reg    <= 1'b0;
            picked_reg  <= 1'b0;
            summary_reg <= '1;
            used_reg    <= '0;
            marks_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            full_reg    <= full_next;
            picked_reg  <= picked_next;
            summary_reg <= summary_next;
            used_reg    <= used_next;
            marks_reg   <= marks_next;
            m_valid_reg <= m_valid_next;
        end
        req_reg     <= req_next;
        idx_reg     <= idx_next;
        res_idx_reg <= res_idx_next;
        status_reg  <= status_next;
        free_reg    <= free_next;
        in_mem_reg  <= in_mem_next;
        freed_reg   <= freed_next;
    end

    assign s_ready           = (state_reg == ST_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_result_index    = res_idx_reg;
    assign m_status          = status_reg;
    assign m_block_free      = free_reg;
    assign m_block_in_memory = in_mem_reg;
    assign m_block_freed     = freed_reg;
    assign m_used_blocks     = used_reg;
    assign m_in_memory_marks = marks_reg;

endmodule

FILE: bench/rcba_checker.sv
// ----------------------------------------------------------------------------
// rcba_checker
// Watches both channels of the block allocator, predicts every result from
// its own copy of the block table and compares each result field by field.
// ----------------------------------------------------------------------------
module rcba_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [1:0]                     s_req_type,
    input  logic [rcba_pkg::IDX_W-1:0]     s_block_index,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [rcba_pkg::IDX_W-1:0]     m_result_index,
    input  logic [1:0]                     m_status,
    input  logic                           m_block_free,
    input  logic                           m_block_in_memory,
    input  logic                           m_block_freed,
    input  logic [rcba_pkg::USED_W-1:0]    m_used_blocks,
    input  logic [rcba_pkg::MARK_W-1:0]    m_in_memory_marks,
    output int                             mismatches,
    output int                             outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import rcba_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic [1:0]        status;
        logic              free;
        logic              in_mem;
        logic              freed;
        logic [USED_W-1:0] used;
        logic [MARK_W-1:0] marks;
    } block_result_t;

    logic [REF_WIDTH-1:0] refs [NUM_BLOCKS];
    logic                 resident [NUM_BLOCKS];
    logic [USED_W-1:0]    blocks_in_use;
    logic [MARK_W-1:0]    mark_events;
    block_result_t        expected_results [$];
    int                   fails = 0;

    // Applies one request to the shadow table and returns what the block
    // should answer.
    function automatic block_result_t serve_request(input logic [1:0]       req,
                                                    input logic [IDX_W-1:0] idx);
        block_result_t r;
        int            slot;
        r.index  = idx;
        r.status = STATUS_OK;
        r.free   = 1'b1;
        r.in_mem = 1'b0;
        r.freed  = 1'b0;
        if (req == REQ_ALLOC) begin
            slot = -1;
            for (int i = 0; i < NUM_BLOCKS; i++) begin
                if (slot < 0 && refs[i] == '0) begin
                    slot = i;
                end
            end
            if (slot >= 0) begin
                refs[slot]    = REF_WIDTH'(1);
                blocks_in_use = blocks_in_use + 1'b1;
                r.index       = IDX_W'(slot);
                r.free        = (refs[slot] == '0);
                r.in_mem      = resident[slot];
            end else begin
                r.index  = '0;
                r.status = STATUS_FULL;
                r.free   = 1'b0;
            end
        end else if (int'(idx) >= NUM_BLOCKS) begin
            r.status = STATUS_NOT_ALLOC;
        end else begin
            if (req == REQ_RELEASE) begin
                if (refs[idx] == '0) begin
                    r.status = STATUS_NOT_ALLOC;
                end else begin
                    refs[idx] = refs[idx] - 1'b1;
                    if (refs[idx] == '0) begin
                        resident[idx] = 1'b0;
                        if (blocks_in_use != '0) begin
                            blocks_in_use = blocks_in_use - 1'b1;
                        end
                        r.freed = 1'b1;
                    end
                end
            end else if (req == REQ_MARK) begin
                resident[idx] = 1'b1;
                mark_events   = mark_events + 1'b1;
            end
            r.free   = (refs[idx] == '0);
            r.in_mem = resident[idx];
        end
        r.used  = blocks_in_use;
        r.marks = mark_events;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            fails++;
            if (fails <= 10) begin
                $display("%0t ns: %s mismatch, expected %0d, got %0d",
                         $time, field, want, got);
            end
        end
    endtask

    always @(posedge aclk) begin
        block_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < NUM_BLOCKS; i++) begin
                refs[i]     = '0;
                resident[i] = 1'b0;
            end
            blocks_in_use = '0;
            mark_events   = '0;
            expected_results.delete();
        end else begin
            // A result never belongs to a request taken at the same edge, so
            // the comparison goes first.
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("%0t ns: result transfer with no request waiting, index %0d",
                                 $time, m_result_index);
                    end
                end else begin
                    want = expected_results.pop_front();
                    check_field("result_index", 32'(want.index), 32'(m_result_index));
                    check_field("status", 32'(want.status), 32'(m_status));
                    check_field("block_free", 32'(want.free), 32'(m_block_free));
                    check_field("block_in_memory", 32'(want.in_mem),
                                32'(m_block_in_memory));
                    check_field("block_freed", 32'(want.freed), 32'(m_block_freed));
                    check_field("used_blocks", 32'(want.used), 32'(m_used_blocks));
                    check_field("in_memory_marks", want.marks, m_in_memory_marks);
                end
            end
            if (s_valid && s_ready) begin
                expected_results.push_back(serve_request(s_req_type, s_block_index));
            end
        end
        outstanding <= expected_results.size();
        mismatches  <= fails;
    end

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Random and directed test of the reference counted block allocator, with
// a separate checker that predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rcba_pkg::*;

    // Cycles without any transfer before the run is declared hung. The
    // clearing pass after reset and the longest legal gap while running both
    // stay within it.
    localparam int IDLE_LIMIT   = 8000;
    // Cycles waited after the last result, in case the block sends extras.
    localparam int DRAIN_CYCLES = 20;

    logic                  aclk;
    logic                  aresetn       = 1'b0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_req_type    = REQ_QUERY;
    logic [IDX_W-1:0]      s_block_index = '0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic [IDX_W-1:0]      m_result_index;
    logic [1:0]            m_status;
    logic                  m_block_free;
    logic                  m_block_in_memory;
    logic                  m_block_freed;
    logic [USED_W-1:0]     m_used_blocks;
    logic [MARK_W-1:0]     m_in_memory_marks;

    int                    mismatches;
    int                    outstanding;
    int                    idle_cycles = 0;
    // While set, the request side sends back to back with no gaps.
    bit                    steady      = 1'b0;

    refcounted_block_allocator uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_block_index     (s_block_index),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_result_index    (m_result_index),
        .m_status          (m_status),
        .m_block_free      (m_block_free),
        .m_block_in_memory (m_block_in_memory),
        .m_block_freed     (m_block_freed),
        .m_used_blocks     (m_used_blocks),
        .m_in_memory_marks (m_in_memory_marks)
    );

    rcba_checker u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_block_index     (s_block_index),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_result_index    (m_result_index),
        .m_status          (m_status),
        .m_block_free      (m_block_free),
        .m_block_in_memory (m_block_in_memory),
        .m_block_freed     (m_block_freed),
        .m_used_blocks     (m_used_blocks),
        .m_in_memory_marks (m_in_memory_marks),
        .mismatches        (mismatches),
        .outstanding       (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Watchdog: any transfer on either channel restarts the count.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side back pressure. Every run sets m_ready once at a falling
    // edge and holds it, so short ready bursts, short stalls, long stalls
    // and long stall-free stretches all occur.
    initial begin
        int pick;
        int len;
        logic level;
        forever begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                level = 1'b1;
                len   = $urandom_range(1, 8);
            end else if (pick < 85) begin
                level = 1'b0;
                len   = $urandom_range(1, 3);
            end else if (pick < 93) begin
                level = 1'b0;
                len   = $urandom_range(8, 40);
            end else begin
                level = 1'b1;
                len   = $urandom_range(30, 120);
            end
            @(negedge aclk);
            m_ready <= level;
            repeat (len - 1) @(negedge aclk);
        end
    end

    // Called at a falling edge. Drops valid for a random number of cycles,
    // unless the gap is zero, in which case valid simply stays high.
    task automatic hold_off();
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        if (steady || pick < 55) begin
            len = 0;
        end else if (pick < 90) begin
            len = $urandom_range(1, 3);
        end else begin
            len = $urandom_range(8, 40);
        end
        if (len > 0) begin
            s_valid <= 1'b0;
            repeat (len) @(negedge aclk);
        end
    endtask

    // Presents one request and holds it until the transfer happens; returns
    // at the falling edge right after the accepting rising edge.
    task automatic send_request(input logic [1:0] req, input logic [IDX_W-1:0] idx);
        hold_off();
        s_valid       <= 1'b1;
        s_req_type    <= req;
        s_block_index <= idx;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // A run of random requests. The weights are in percent and the query
    // takes what is left. Three in four addresses fall in the low window,
    // where allocation hands out blocks, so most releases hit a live block;
    // the rest span the whole index range.
    task automatic random_requests(input int count, input int alloc_pct,
                                   input int release_pct, input int mark_pct,
                                   input int window);
        int         pick;
        logic [1:0] req;
        logic [IDX_W-1:0] idx;
        for (int n = 0; n < count; n++) begin
            if (n % 50 == 0) begin
                steady = ($urandom_range(0, 4) == 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < alloc_pct) begin
                req = REQ_ALLOC;
            end else if (pick < alloc_pct + release_pct) begin
                req = REQ_RELEASE;
            end else if (pick < alloc_pct + release_pct + mark_pct) begin
                req = REQ_MARK;
            end else begin
                req = REQ_QUERY;
            end
            if ($urandom_range(0, 3) == 0) begin
                idx = IDX_W'($urandom_range(0, NUM_BLOCKS - 1));
            end else begin
                idx = IDX_W'($urandom_range(0, window - 1));
            end
            send_request(req, idx);
        end
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part: queries and releases of free blocks, marking a
        // free block, allocation that keeps a block's in-memory flag,
        // freeing a marked block, a double release, and the index extremes.
        send_request(REQ_QUERY,   10'd0);
        send_request(REQ_RELEASE, 10'd0);
        send_request(REQ_MARK,    10'd5);
        send_request(REQ_QUERY,   10'd5);
        send_request(REQ_ALLOC,   10'd1023);
        send_request(REQ_ALLOC,   10'd0);
        send_request(REQ_ALLOC,   10'd682);
        send_request(REQ_MARK,    10'd1);
        send_request(REQ_QUERY,   10'd1);
        send_request(REQ_RELEASE, 10'd1);
        send_request(REQ_QUERY,   10'd1);
        send_request(REQ_MARK,    10'd3);
        send_request(REQ_ALLOC,   10'd341);
        send_request(REQ_ALLOC,   10'd0);
        send_request(REQ_RELEASE, 10'd1023);
        send_request(REQ_MARK,    10'd1023);
        send_request(REQ_QUERY,   10'd1023);
        send_request(REQ_QUERY,   10'd682);
        send_request(REQ_RELEASE, 10'd341);
        send_request(REQ_RELEASE, 10'd0);
        send_request(REQ_RELEASE, 10'd0);
        send_request(REQ_ALLOC,   10'd0);

        // Mixed traffic over a partly used table.
        random_requests(600, 35, 30, 20, 64);
        // Mostly allocations: more than the table holds, so the table fills
        // and the full answer shows up many times.
        random_requests(1100, 95, 0, 0, NUM_BLOCKS);
        // Releases, mostly in the low window and the rest across the whole table,
        // punch holes that allocation then has to find, also in the upper groups.
        random_requests(350, 30, 40, 15, 64);

        s_valid <= 1'b0;
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/rcba_pkg.sv
hdl/rcba_ram.sv
hdl/refcounted_block_allocator.sv
bench/rcba_checker.sv
bench/tb.sv
